[rtl/lant_pkg.sv]
// ---------------------------------------------------------------------------
// lant_pkg: shared types and constants for the multicolor ant stepper
// Color and heading encodings, configuration register indexes.
// ---------------------------------------------------------------------------
package lant_pkg;

    localparam int COLOR_W = 4;
    localparam int HEAD_W  = 2;
    localparam int CFG_IDX_W = 1;

    typedef logic [COLOR_W-1:0]   t_color;
    typedef logic [HEAD_W-1:0]    t_heading;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Headings; a left turn adds one, a right turn subtracts one
    localparam t_heading HEAD_UP    = 2'd0;
    localparam t_heading HEAD_LEFT  = 2'd1;
    localparam t_heading HEAD_DOWN  = 2'd2;
    localparam t_heading HEAD_RIGHT = 2'd3;

    // Configuration register indexes
    localparam t_cfg_idx CFG_NEXT_COLOR = 1'b0;
    localparam t_cfg_idx CFG_TURN_LEFT  = 1'b1;

    localparam t_color COLOR_BLANK = 4'd0;

endpackage

[rtl/lant_grid.sv]
// ---------------------------------------------------------------------------
// lant_grid: grid color memory
// One write port and one registered read port. After reset a sweep writes
// color 0 into every cell, one cell per cycle, while o_clearing is high.
// ---------------------------------------------------------------------------
module lant_grid #(
    parameter int AW = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output lant_pkg::t_color  o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  lant_pkg::t_color  i_wr_data,
    output logic              o_clearing
);

    localparam int DEPTH = 2 ** AW;

    lant_pkg::t_color mem [DEPTH];
    lant_pkg::t_color r_rd_data;
    logic             r_clr;
    logic [AW-1:0]    r_clr_addr;

    // Sweep the whole array after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (&r_clr_addr) begin
                r_clr <= 1'b0;
            end
        end
    end

    // Write port: sweep has priority, the stepper never writes during it
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            mem[r_clr_addr] <= lant_pkg::COLOR_BLANK;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr;

endmodule

[rtl/multicolor_langton_ant_step_top.sv]
// ---------------------------------------------------------------------------
// multicolor_langton_ant_step_top: multicolor ant stepper on a color grid
// Reads the ant's cell, repaints it, turns, moves; one result per tick beat.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_tick) takes one beat per step
//   request; tick 1 advances the ant, tick 0 just reports its current cell.
//   Output channel (o_out_valid/i_out_ready) returns one beat per input beat:
//   painted cell, painted color, heading after the turn and the halt flag.
//   Config channel (i_cfg_valid/o_cfg_ready) is always ready; index 0 writes
//   the next-color table, index 1 the left-turn mask.
// Timing:
//   An input beat is taken at the edge that reads its grid cell; the result
//   moves to the output register when that is free, and only then is a new
//   beat taken. The rate is set by the read-modify-write of the grid memory,
//   whose next address depends on the current step.
// Reset:
//   The grid is swept to color 0, one cell per cycle, GRID_SIDE rounded up
//   to a power of two, squared cells (262144 by default); o_in_ready stays
//   low during the sweep. Config writes are taken throughout.
// Stall:
//   A result waiting in the output register does not block the next input
//   beat; that beat's result holds in the compute stage until the output
//   register drains.
// ---------------------------------------------------------------------------
module multicolor_langton_ant_step_top #(
    parameter int GRID_SIDE  = 512,
    parameter int NUM_COLORS = 11
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_tick,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [$clog2(GRID_SIDE)-1:0]         o_cell_col,
    output logic [$clog2(GRID_SIDE)-1:0]         o_cell_row,
    output lant_pkg::t_color                     o_painted_color,
    output lant_pkg::t_heading                   o_new_heading,
    output logic                                 o_halted,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  lant_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [lant_pkg::COLOR_W*NUM_COLORS-1:0] i_cfg_data
);

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int AW    = 2 * CW;
    localparam int TBL_W = lant_pkg::COLOR_W * NUM_COLORS;
    localparam logic [CW-1:0] COORD_MAX    = CW'(GRID_SIDE - 1);
    localparam logic [CW-1:0] COORD_CENTER = CW'(GRID_SIDE / 2);
    localparam logic [lant_pkg::COLOR_W:0] NC = (lant_pkg::COLOR_W + 1)'(NUM_COLORS);

    // Configuration registers
    logic [TBL_W-1:0]      r_next_tbl;
    logic [NUM_COLORS-1:0] r_turn_left;

    // Ant state
    logic [CW-1:0]      r_col;
    logic [CW-1:0]      r_row;
    lant_pkg::t_heading r_head;
    logic               r_stopped;

    // Compute stage
    logic r_busy;
    logic r_tick;

    // Output register
    logic                 r_out_valid;
    logic [CW-1:0]        r_out_col;
    logic [CW-1:0]        r_out_row;
    lant_pkg::t_color     r_out_color;
    lant_pkg::t_heading   r_out_head;
    logic                 r_out_halted;

    logic               clearing;
    logic               in_accept;
    logic               done;
    logic               go;
    lant_pkg::t_color   cur;
    lant_pkg::t_color   nib;
    lant_pkg::t_color   paint;
    logic               turn_left;
    lant_pkg::t_heading head_new;
    logic               off;
    logic [CW-1:0]      n_col;
    logic [CW-1:0]      n_row;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy && !clearing;
    assign in_accept   = i_in_valid && o_in_ready;
    assign done        = r_busy && (!r_out_valid || i_out_ready);
    assign go          = r_tick && !r_stopped;

    // Grid memory
    lant_grid #(
        .AW(AW)
    ) u_grid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_accept),
        .i_rd_addr  ({r_row, r_col}),
        .o_rd_data  (cur),
        .i_wr_en    (done && go),
        .i_wr_addr  ({r_row, r_col}),
        .i_wr_data  (paint),
        .o_clearing (clearing)
    );

    // Look up the color painted over the current one
    always_comb begin
        nib = lant_pkg::COLOR_BLANK;
        for (int i = 0; i < NUM_COLORS; i++) begin
            if (cur == lant_pkg::COLOR_W'(i)) begin
                nib = r_next_tbl[i*lant_pkg::COLOR_W +: lant_pkg::COLOR_W];
            end
        end
        paint = ({1'b0, nib} < NC) ? nib : lant_pkg::COLOR_BLANK;
    end

    // Turn by the rule of the painted color
    always_comb begin
        turn_left = 1'b0;
        for (int i = 0; i < NUM_COLORS; i++) begin
            if (paint == lant_pkg::COLOR_W'(i)) begin
                turn_left = r_turn_left[i];
            end
        end
        head_new = turn_left ? r_head + lant_pkg::HEAD_W'(1)
                             : r_head - lant_pkg::HEAD_W'(1);
    end

    // Move one cell; flag a step off the grid
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        off   = 1'b0;
        unique case (head_new)
            lant_pkg::HEAD_UP: begin
                if (r_row == '0) off = 1'b1;
                else             n_row = r_row - CW'(1);
            end
            lant_pkg::HEAD_LEFT: begin
                if (r_col == '0) off = 1'b1;
                else             n_col = r_col - CW'(1);
            end
            lant_pkg::HEAD_DOWN: begin
                if (r_row == COORD_MAX) off = 1'b1;
                else                    n_row = r_row + CW'(1);
            end
            lant_pkg::HEAD_RIGHT: begin
                if (r_col == COORD_MAX) off = 1'b1;
                else                    n_col = r_col + CW'(1);
            end
            default: begin
                off = 1'b0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_tbl  <= TBL_W'(1);
            r_turn_left <= NUM_COLORS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lant_pkg::CFG_NEXT_COLOR: r_next_tbl  <= i_cfg_data;
                lant_pkg::CFG_TURN_LEFT:  r_turn_left <= i_cfg_data[NUM_COLORS-1:0];
                default: ;
            endcase
        end
    end

    // Compute stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_accept) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_tick <= i_tick;
        end
    end

    // Advance the ant when a step completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= COORD_CENTER;
            r_row     <= COORD_CENTER;
            r_head    <= lant_pkg::HEAD_UP;
            r_stopped <= 1'b0;
        end else if (done && go) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_head    <= head_new;
            r_stopped <= off;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_col    <= r_col;
            r_out_row    <= r_row;
            r_out_color  <= go ? paint : cur;
            r_out_head   <= go ? head_new : r_head;
            r_out_halted <= go ? off : r_stopped;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cell_col      = r_out_col;
    assign o_cell_row      = r_out_row;
    assign o_painted_color = r_out_color;
    assign o_new_heading   = r_out_head;
    assign o_halted        = r_out_halted;

endmodule

[rtl/lant_checker.sv]
// ---------------------------------------------------------------------------
// lant_checker: port-level checks for the ant stepper
// Watches the top-level ports only; attached by the bind below.
// ---------------------------------------------------------------------------
module lant_checker #(
    parameter int GRID_SIDE = 512
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [$clog2(GRID_SIDE)-1:0] o_cell_col,
    input logic [$clog2(GRID_SIDE)-1:0] o_cell_row,
    input lant_pkg::t_color             o_painted_color,
    input lant_pkg::t_heading           o_new_heading,
    input logic                         o_halted
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cell_col)
            && $stable(o_cell_row) && $stable(o_painted_color)
            && $stable(o_new_heading) && $stable(o_halted))
        else $error("result beat changed while stalled");

    // Drop input ready while the grid is swept after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_in_ready)
        else $error("input ready during grid sweep");

    // Interlock the read-modify-write: no beat in the cycle after one
    a_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input beat taken back to back");

    // Keep the halt flag once shown
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_halted |=> o_halted)
        else $error("halt flag cleared");

endmodule

bind multicolor_langton_ant_step_top lant_checker #(
    .GRID_SIDE(GRID_SIDE)
) u_lant_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_cell_col      (o_cell_col),
    .o_cell_row      (o_cell_row),
    .o_painted_color (o_painted_color),
    .o_new_heading   (o_new_heading),
    .o_halted        (o_halted)
);

[dv/tb_multicolor_langton_ant_step_top.sv]
// ---------------------------------------------------------------------------
// tb_multicolor_langton_ant_step_top: self-checking bench for the ant stepper
// Drives tick beats through the valid/ready input channel, reprograms the
// recolor table and left-turn mask between phases, and checks every result
// beat against a bench-side model of the grid, ant position and heading.
// ---------------------------------------------------------------------------
module tb_multicolor_langton_ant_step_top;

    localparam int SIDE         = 512;
    localparam int COLORS       = 11;
    localparam int COORD_W      = $clog2(SIDE);
    localparam int RULE_W       = lant_pkg::COLOR_W * COLORS;
    localparam int SINK_HOLD    = 200;
    localparam int WALK_CAP     = 1100;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam logic [RULE_W-1:0] STAIR_TABLE = {COLORS{4'h1}};

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        lant_pkg::t_color   color;
        lant_pkg::t_heading dir;
        logic               halted;
    } t_ant_beat;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    i_tick       = 1'b0;
    logic                    i_out_ready  = 1'b0;
    logic                    i_cfg_valid  = 1'b0;
    lant_pkg::t_cfg_idx      i_cfg_index  = lant_pkg::CFG_NEXT_COLOR;
    logic [RULE_W-1:0]       i_cfg_data   = '0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic [COORD_W-1:0]      o_cell_col;
    logic [COORD_W-1:0]      o_cell_row;
    lant_pkg::t_color        o_painted_color;
    lant_pkg::t_heading      o_new_heading;
    logic                    o_halted;
    logic                    o_cfg_ready;

    // Bench-side copy of the grid, the ant and the rules
    bit   [lant_pkg::COLOR_W-1:0] cell_colors [SIDE*SIDE];
    logic [COORD_W-1:0]      ant_x        = COORD_W'(SIDE / 2);
    logic [COORD_W-1:0]      ant_y        = COORD_W'(SIDE / 2);
    lant_pkg::t_heading      ant_dir      = lant_pkg::HEAD_UP;
    logic                    ant_parked   = 1'b0;
    logic [RULE_W-1:0]       recolor_table  = RULE_W'(1);
    logic [COLORS-1:0]       left_turn_bits = COLORS'(1);

    t_ant_beat               expected_cells [$];
    int unsigned             mismatches   = 0;
    int unsigned             cycle_count  = 0;
    bit                      steady_traffic = 1'b0;
    bit                      sink_hold_req  = 1'b0;
    bit                      sink_hold_seen = 1'b0;
    int unsigned             sink_hold_left = 0;

    multicolor_langton_ant_step_top #(
        .GRID_SIDE  (SIDE),
        .NUM_COLORS (COLORS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_tick          (i_tick),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cell_col      (o_cell_col),
        .o_cell_row      (o_cell_row),
        .o_painted_color (o_painted_color),
        .o_new_heading   (o_new_heading),
        .o_halted        (o_halted),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Bound the run; the reset sweep alone covers SIDE*SIDE cells
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Model one beat: report the cell, or on a live tick read, repaint, turn, move or park
    function automatic t_ant_beat paint_and_move(input logic tick);
        t_ant_beat        res;
        int unsigned      cell_idx;
        lant_pkg::t_color cur;
        lant_pkg::t_color paint;
        cell_idx = ant_y * SIDE + ant_x;
        cur      = cell_colors[cell_idx];
        res.col  = ant_x;
        res.row  = ant_y;
        if (!tick || ant_parked) begin
            res.color  = cur;
            res.dir    = ant_dir;
            res.halted = ant_parked;
            return res;
        end
        paint = recolor_table[cur*lant_pkg::COLOR_W +: lant_pkg::COLOR_W];
        // Unknown colors count as blank
        if (paint >= COLORS)
            paint = lant_pkg::COLOR_BLANK;
        cell_colors[cell_idx] = paint;
        if (left_turn_bits[paint])
            ant_dir = ant_dir + 1'b1;
        else
            ant_dir = ant_dir - 1'b1;
        case (ant_dir)
            lant_pkg::HEAD_UP: begin
                if (ant_y == 0) ant_parked = 1'b1; else ant_y = ant_y - 1'b1;
            end
            lant_pkg::HEAD_LEFT: begin
                if (ant_x == 0) ant_parked = 1'b1; else ant_x = ant_x - 1'b1;
            end
            lant_pkg::HEAD_DOWN: begin
                if (ant_y == SIDE - 1) ant_parked = 1'b1; else ant_y = ant_y + 1'b1;
            end
            default: begin
                if (ant_x == SIDE - 1) ant_parked = 1'b1; else ant_x = ant_x + 1'b1;
            end
        endcase
        res.color  = paint;
        res.dir    = ant_dir;
        res.halted = ant_parked;
        return res;
    endfunction

    // Offer one tick beat, then log its expected result once accepted
    task automatic send_tick(input logic tick);
        int unsigned gap;
        gap = 0;
        if (!steady_traffic)
            while ($urandom_range(99) < 10) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_tick     <= tick;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        expected_cells.push_back(paint_and_move(tick));
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both rule registers back to back while the block is idle
    task automatic program_rules(input logic [RULE_W-1:0] table_word,
                                 input logic [COLORS-1:0] mask);
        logic [RULE_W-1:0] mask_word;
        drain_results();
        mask_word = RULE_W'({$urandom(), $urandom()});
        mask_word[COLORS-1:0] = mask;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= lant_pkg::CFG_NEXT_COLOR;
        i_cfg_data  <= table_word;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_index <= lant_pkg::CFG_TURN_LEFT;
        i_cfg_data  <= mask_word;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        recolor_table  = table_word;
        left_turn_bits = mask_word[COLORS-1:0];
    endtask

    // Sink side: random stalls, or a long hold counted here on request
    always @(posedge i_clk) begin
        if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
            i_out_ready    <= 1'b0;
        end else if (sink_hold_req != sink_hold_seen) begin
            sink_hold_seen <= sink_hold_req;
            sink_hold_left <= SINK_HOLD;
            i_out_ready    <= 1'b0;
        end else begin
            i_out_ready <= steady_traffic || ($urandom_range(99) >= 10);
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_ant_beat want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_cells.size() == 0) begin
                $error("result beat with nothing expected");
                mismatches++;
            end else begin
                want = expected_cells.pop_front();
                check_field("cell_col", 16'(want.col), 16'(o_cell_col));
                check_field("cell_row", 16'(want.row), 16'(o_cell_row));
                check_field("painted_color", 16'(want.color), 16'(o_painted_color));
                check_field("new_heading", 16'(want.dir), 16'(o_new_heading));
                check_field("halted", 16'(want.halted), 16'(o_halted));
            end
        end
    end

    // Idle reports at the center, then a few steps under the reset rules
    task automatic test_reset_report();
        send_tick(1'b0);
        send_tick(1'b0);
        repeat (6) send_tick(1'b1);
    endtask

    // All-unknown colors, all-blank, full cycle with wrap to unknown, max color
    task automatic test_rule_extremes();
        logic [RULE_W-1:0] tables [4];
        logic [COLORS-1:0] masks  [4];
        tables[0] = '1;               masks[0] = '1;
        tables[1] = '0;               masks[1] = '0;
        tables[2] = 44'hBA987654321;  masks[2] = 11'h555;
        tables[3] = 44'h0123456789A;  masks[3] = 11'h2AA;
        for (int s = 0; s < 4; s++) begin
            program_rules(tables[s], masks[s]);
            send_tick(1'b1);
            send_tick(1'b1);
            send_tick(1'b0);
            send_tick(1'b1);
        end
    endtask

    // Random rule sets, mostly in-range colors, mostly real steps
    task automatic test_random_rules();
        logic [RULE_W-1:0] table_word;
        for (int p = 0; p < 5; p++) begin
            for (int n = 0; n < COLORS; n++)
                table_word[n*lant_pkg::COLOR_W +: lant_pkg::COLOR_W] =
                    ($urandom_range(99) < 80) ?
                    lant_pkg::COLOR_W'($urandom_range(COLORS - 1)) :
                    lant_pkg::COLOR_W'($urandom_range(15, COLORS));
            program_rules(table_word, COLORS'($urandom_range(2047)));
            repeat (60) send_tick($urandom_range(99) < 85);
        end
    endtask

    // Long stretch with no idling on either side
    task automatic test_back_to_back();
        steady_traffic = 1'b1;
        repeat (150) send_tick($urandom_range(99) < 90);
        steady_traffic = 1'b0;
    endtask

    // Hold the sink while beats keep coming, pause until all drained, then send mixed beats
    task automatic test_output_backpressure();
        steady_traffic = 1'b1;
        sink_hold_req  = ~sink_hold_req;
        repeat (30) send_tick(1'b1);
        steady_traffic = 1'b0;
        drain_results();
        repeat (20) send_tick($urandom_range(1));
    endtask

    // Paint every cell color 1 and flip its turn rule each step, so the ant
    // walks a diagonal staircase over fresh cells until it leaves the grid
    task automatic test_walk_off_grid();
        int unsigned steps;
        logic        go_left;
        steps   = 0;
        go_left = 1'b1;
        while (!ant_parked && steps < WALK_CAP) begin
            program_rules(STAIR_TABLE, go_left ? COLORS'(2) : COLORS'(0));
            send_tick(1'b1);
            go_left = !go_left;
            steps++;
        end
        // Once parked, every beat is a plain report
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_report();
        test_rule_extremes();
        test_random_rules();
        test_back_to_back();
        test_output_backpressure();
        test_walk_off_grid();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
